// ----- rtl/adaptive_poll_interval_controller_core_assert.svh -----
// assertion macros for the adaptive poll interval controller
// expects clk and rst_n in the scope where a macro is used
`ifndef ADAPTIVE_POLL_INTERVAL_CONTROLLER_CORE_ASSERT_SVH
`define ADAPTIVE_POLL_INTERVAL_CONTROLLER_CORE_ASSERT_SVH

// condition in one cycle implies a consequence in the next
`define APIC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// condition implies a consequence in the same cycle
`define APIC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- rtl/apic_pkg.sv -----
// shared types, constants and helpers of the adaptive poll interval controller
// no dependencies
`timescale 1ns / 1ps

package apic_pkg;

    localparam int unsigned CFG_IDX_W = 4;

    localparam logic [15:0] FLOOR_MS        = 16'd5;
    localparam logic [14:0] FLOOR_MS_15     = 15'd5;
    localparam logic [15:0] RUN_MAX         = 16'hFFFF;

    localparam logic [15:0] RST_MIN_INTERVAL  = 16'd5;
    localparam logic [15:0] RST_MAX_INTERVAL  = 16'd1000;
    localparam logic [14:0] RST_LAT_TARGET    = 15'd50;
    localparam logic [14:0] RST_LAT_SLACK     = 15'd20;
    localparam logic [15:0] RST_BACKOFF_STEP  = 16'd20;
    localparam logic [15:0] RST_RECOVERY_STEP = 16'd10;
    localparam logic [15:0] RST_FAIL_THR      = 16'd3;
    localparam logic [15:0] RST_OK_THR        = 16'd5;

    typedef enum logic [1:0] {
        OP_SUCCESS = 2'd0,
        OP_FAILURE = 2'd1,
        OP_TIMEOUT = 2'd2,
        OP_RESTART = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_INTERVAL      = 4'd0,
        CFG_MAX_INTERVAL      = 4'd1,
        CFG_LATENCY_TARGET    = 4'd2,
        CFG_LATENCY_SLACK     = 4'd3,
        CFG_BACKOFF_STEP      = 4'd4,
        CFG_RECOVERY_STEP     = 4'd5,
        CFG_FAILURE_THRESHOLD = 4'd6,
        CFG_SUCCESS_THRESHOLD = 4'd7
    } cfg_idx_t;

    // effective settings as seen by the update logic
    typedef struct packed {
        logic [15:0] eff_min;
        logic [15:0] eff_max;
        logic [14:0] eff_target;
        logic [14:0] slack;
        logic [15:0] backoff_step;
        logic [15:0] recovery_step;
        logic [15:0] fail_thr;
        logic [15:0] ok_thr;
    } cfg_t;

    typedef struct packed {
        op_t         opcode;
        logic [15:0] latency;
        logic [15:0] start_interval;
    } item_t;

    typedef struct packed {
        logic [15:0] interval;
        logic [15:0] last_lat;
        logic [15:0] peak_lat;
        logic [31:0] lat_sum;
        logic [31:0] count;
        logic [15:0] fail_run;
        logic [15:0] ok_run;
    } stats_t;

    function automatic logic [15:0] clamp_interval(input logic [15:0] v,
                                                   input logic [15:0] lo,
                                                   input logic [15:0] hi);
        logic [15:0] r;
        r = (v < lo) ? lo : v;
        r = (r > hi) ? hi : r;
        return r;
    endfunction

endpackage

// ----- rtl/apic_cfg.sv -----
// configuration register file with effective min, max and target
// depends on apic_pkg
`timescale 1ns / 1ps

module apic_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [apic_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [15:0]                    wr_data,
    output apic_pkg::cfg_t                 cfg
);

    logic [15:0] min_reg;
    logic [15:0] max_reg;
    logic [14:0] target_reg;
    logic [14:0] slack_reg;
    logic [15:0] backoff_reg;
    logic [15:0] recovery_reg;
    logic [15:0] fail_thr_reg;
    logic [15:0] ok_thr_reg;
    logic [15:0] eff_min;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg      <= apic_pkg::RST_MIN_INTERVAL;
            max_reg      <= apic_pkg::RST_MAX_INTERVAL;
            target_reg   <= apic_pkg::RST_LAT_TARGET;
            slack_reg    <= apic_pkg::RST_LAT_SLACK;
            backoff_reg  <= apic_pkg::RST_BACKOFF_STEP;
            recovery_reg <= apic_pkg::RST_RECOVERY_STEP;
            fail_thr_reg <= apic_pkg::RST_FAIL_THR;
            ok_thr_reg   <= apic_pkg::RST_OK_THR;
        end
        else if (wr_en)
        begin
            // unknown indexes fall through and are dropped
            unique case (apic_pkg::cfg_idx_t'(wr_index))
                apic_pkg::CFG_MIN_INTERVAL:      min_reg      <= wr_data;
                apic_pkg::CFG_MAX_INTERVAL:      max_reg      <= wr_data;
                apic_pkg::CFG_LATENCY_TARGET:    target_reg   <= wr_data[14:0];
                apic_pkg::CFG_LATENCY_SLACK:     slack_reg    <= wr_data[14:0];
                apic_pkg::CFG_BACKOFF_STEP:      backoff_reg  <= wr_data;
                apic_pkg::CFG_RECOVERY_STEP:     recovery_reg <= wr_data;
                apic_pkg::CFG_FAILURE_THRESHOLD: fail_thr_reg <= wr_data;
                apic_pkg::CFG_SUCCESS_THRESHOLD: ok_thr_reg   <= wr_data;
                default: ;
            endcase
        end
    end

    assign eff_min = (min_reg < apic_pkg::FLOOR_MS) ? apic_pkg::FLOOR_MS : min_reg;

    always_comb
    begin
        cfg.eff_min       = eff_min;
        cfg.eff_max       = (max_reg < eff_min) ? eff_min : max_reg;
        cfg.eff_target    = (target_reg < apic_pkg::FLOOR_MS_15) ? apic_pkg::FLOOR_MS_15
                                                                 : target_reg;
        cfg.slack         = slack_reg;
        cfg.backoff_step  = backoff_reg;
        cfg.recovery_step = recovery_reg;
        cfg.fail_thr      = fail_thr_reg;
        cfg.ok_thr        = ok_thr_reg;
    end

endmodule

// ----- rtl/apic_engine.sv -----
// interval and statistics state with its single-pass update
// depends on apic_pkg
`timescale 1ns / 1ps

module apic_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  apic_pkg::item_t  item,
    input  apic_pkg::cfg_t   cfg,
    output apic_pkg::stats_t state
);

    apic_pkg::stats_t state_reg;
    apic_pkg::stats_t state_next;

    always_comb
    begin
        logic [15:0] limit;
        logic [15:0] lat;
        logic [15:0] ok_inc;
        logic [15:0] fail_inc;
        logic [16:0] rec_delta;
        logic [15:0] over;
        logic [16:0] back_delta;
        logic [17:0] grown;
        logic [15:0] iv;
        logic        recover;
        logic        backoff;

        limit = {1'b0, cfg.eff_target} + {1'b0, cfg.slack};
        // a timeout counts as a failure sitting exactly on the limit
        lat = (item.opcode == apic_pkg::OP_TIMEOUT) ? limit : item.latency;

        ok_inc   = (state_reg.ok_run == apic_pkg::RUN_MAX) ? state_reg.ok_run
                                                           : state_reg.ok_run + 16'd1;
        fail_inc = (state_reg.fail_run == apic_pkg::RUN_MAX) ? state_reg.fail_run
                                                             : state_reg.fail_run + 16'd1;

        rec_delta = {1'b0, cfg.recovery_step}
                  + ((lat < {1'b0, cfg.eff_target}) ? {1'b0, cfg.recovery_step} : 17'd0);
        recover   = (state_reg.interval > cfg.eff_min) && (lat <= limit)
                 && (ok_inc >= cfg.ok_thr);

        over       = (lat > limit) ? lat - limit : 16'd0;
        back_delta = {1'b0, cfg.backoff_step} + {1'b0, over};
        grown      = {2'b00, state_reg.interval} + {1'b0, back_delta};
        backoff    = (lat >= limit) || (fail_inc >= cfg.fail_thr);

        state_next          = state_reg;
        state_next.last_lat = lat;
        state_next.peak_lat = (lat > state_reg.peak_lat) ? lat : state_reg.peak_lat;
        state_next.lat_sum  = state_reg.lat_sum + {16'd0, lat};
        state_next.count    = state_reg.count + 32'd1;
        iv                  = state_reg.interval;

        unique case (item.opcode)
            apic_pkg::OP_SUCCESS:
            begin
                state_next.fail_run = 16'd0;
                state_next.ok_run   = recover ? 16'd0 : ok_inc;
                if (recover)
                begin
                    iv = ({1'b0, state_reg.interval} > rec_delta)
                       ? state_reg.interval - rec_delta[15:0] : cfg.eff_min;
                end
                state_next.interval = apic_pkg::clamp_interval(iv, cfg.eff_min, cfg.eff_max);
            end
            apic_pkg::OP_FAILURE, apic_pkg::OP_TIMEOUT:
            begin
                state_next.ok_run   = 16'd0;
                state_next.fail_run = backoff ? 16'd0 : fail_inc;
                if (backoff)
                begin
                    iv = (grown < {2'b00, cfg.eff_max}) ? grown[15:0] : cfg.eff_max;
                end
                state_next.interval = apic_pkg::clamp_interval(iv, cfg.eff_min, cfg.eff_max);
            end
            apic_pkg::OP_RESTART:
            begin
                state_next.interval = apic_pkg::clamp_interval(item.start_interval,
                                                               cfg.eff_min, cfg.eff_max);
                state_next.last_lat = 16'd0;
                state_next.peak_lat = 16'd0;
                state_next.lat_sum  = 32'd0;
                state_next.count    = 32'd0;
                state_next.fail_run = 16'd0;
                state_next.ok_run   = 16'd0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.interval <= apic_pkg::RST_MIN_INTERVAL;
            state_reg.last_lat <= 16'd0;
            state_reg.peak_lat <= 16'd0;
            state_reg.lat_sum  <= 32'd0;
            state_reg.count    <= 32'd0;
            state_reg.fail_run <= 16'd0;
            state_reg.ok_run   <= 16'd0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

// ----- rtl/adaptive_poll_interval_controller_core.sv -----
// top level of the adaptive poll interval controller: input stage and handshakes
// depends on apic_pkg, apic_cfg, apic_engine and the assertion header
`timescale 1ns / 1ps

// usage
// - poll outcome events enter on in_valid/in_ready with opcode, latency and
//   start_interval; each event gives exactly one result on out_valid/out_ready
// - the result is the state after the event: interval, latest and peak latency,
//   wrapping latency sum and sample count, failure and success runs
// - settings are written on cfg_valid/cfg_ready (cfg_index, cfg_data); cfg_ready
//   is always high, unknown indexes are dropped; write only while the block is idle
// - an event is registered on transfer, then processed into the state registers
//   once the current result is gone or leaving; the state registers drive the
//   result ports directly
// - throughput is one event per cycle while the receiver takes every result
// - a stalled receiver holds the result and the state; one more event waits in the
//   input register, after which in_ready drops
// - reset clears both stages, puts the interval at 5 ms, clears all statistics and
//   loads the default settings

`include "adaptive_poll_interval_controller_core_assert.svh"

module adaptive_poll_interval_controller_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     opcode,
    input  logic [15:0]                    latency,
    input  logic [15:0]                    start_interval,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [15:0]                    interval,
    output logic [15:0]                    last_latency,
    output logic [15:0]                    peak_latency,
    output logic [31:0]                    latency_sum,
    output logic [31:0]                    sample_count,
    output logic [15:0]                    fail_run,
    output logic [15:0]                    ok_run,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [apic_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_data
);

    apic_pkg::cfg_t   cfg;
    apic_pkg::stats_t state;
    apic_pkg::item_t  in_item_reg;
    logic             in_valid_reg;
    logic             out_valid_reg;
    logic             fire;
    logic             pending_stuck;
    logic             restart_fire;
    logic             stats_clear;

    assign cfg_ready = 1'b1;

    apic_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // the state registers double as the result register, so update only
    // when the current result is gone or leaving
    assign fire     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg.opcode         <= apic_pkg::op_t'(opcode);
            in_item_reg.latency        <= latency;
            in_item_reg.start_interval <= start_interval;
        end
    end

    apic_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (in_item_reg),
        .cfg   (cfg),
        .state (state)
    );

    assign out_valid    = out_valid_reg;
    assign interval     = state.interval;
    assign last_latency = state.last_lat;
    assign peak_latency = state.peak_lat;
    assign latency_sum  = state.lat_sum;
    assign sample_count = state.count;
    assign fail_run     = state.fail_run;
    assign ok_run       = state.ok_run;

    assign pending_stuck = in_valid_reg && !fire;
    assign restart_fire  = fire && (in_item_reg.opcode == apic_pkg::OP_RESTART);
    assign stats_clear   = (sample_count == 32'd0) && (fail_run == 16'd0) && (ok_run == 16'd0);

    `APIC_ASSERT_NEXT(a_fire_gives_result, fire, out_valid_reg, "update without result")
    `APIC_ASSERT_NEXT(a_state_holds, !fire, $stable(state), "state moved without an event")
    `APIC_ASSERT_NEXT(a_pending_holds, pending_stuck, in_valid_reg, "pending event lost")
    `APIC_ASSERT_NEXT(a_item_holds, pending_stuck, $stable(in_item_reg), "pending event changed")
    `APIC_ASSERT_NEXT(a_restart_clears, restart_fire, stats_clear, "restart left statistics")

endmodule
